FILE: rtl/tisp_pkg.sv
// ---------------------------------------------------------------------------
// tisp_pkg: text image stream parser package
// Item types, parser phases, dimension limits and the clamp function.
// ---------------------------------------------------------------------------
package tisp_pkg;

    localparam int unsigned MIN_W = 1;
    localparam int unsigned MAX_W = 4096;
    localparam int unsigned MIN_H = 1;
    localparam int unsigned MAX_H = 4096;

    localparam int DIM_W   = 13;
    localparam int POS_W   = 12;
    localparam int COMP_W  = 8;
    localparam int ACC_W   = 32;

    localparam logic [7:0] CHAR_NL   = 8'h0A;
    localparam logic [7:0] CHAR_DASH = 8'h2D;
    localparam logic [7:0] CHAR_ZERO = 8'h30;

    localparam logic KIND_HEADER = 1'b0;
    localparam logic KIND_PIXEL  = 1'b1;

    typedef enum logic [3:0] {
        PH_WIDTH,
        PH_DASH_OR_H,
        PH_HEIGHT,
        PH_SKIP2,
        PH_SKIP1,
        PH_RED,
        PH_GREEN,
        PH_BLUE,
        PH_DONE
    } phase_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       start_req;
    } char_item_t;

    typedef struct packed {
        logic              kind;
        logic [DIM_W-1:0]  width;
        logic [DIM_W-1:0]  height;
        logic              dims_clamped;
        logic [POS_W-1:0]  row;
        logic [POS_W-1:0]  col;
        logic [COMP_W-1:0] red;
        logic [COMP_W-1:0] green;
        logic [COMP_W-1:0] blue;
        logic              last_pixel;
    } result_item_t;

    typedef struct packed {
        logic              kind;
        logic [DIM_W-1:0]  width;
        logic [DIM_W-1:0]  height;
        logic              dims_clamped;
        logic [POS_W-1:0]  row;
        logic [POS_W-1:0]  col;
        logic [COMP_W-1:0] red;
        logic [COMP_W-1:0] green;
        logic [COMP_W-1:0] blue;
    } event_rec_t;

    typedef struct packed {
        logic             hit;
        logic [DIM_W-1:0] value;
    } dim_clamp_t;

    function automatic dim_clamp_t clamp_dim(logic [ACC_W-1:0] v,
                                             logic [ACC_W-1:0] lo,
                                             logic [ACC_W-1:0] hi);
        dim_clamp_t r;
        if (v[ACC_W-1] || (v < lo)) begin
            r.hit   = 1'b1;
            r.value = lo[DIM_W-1:0];
        end else if (v > hi) begin
            r.hit   = 1'b1;
            r.value = hi[DIM_W-1:0];
        end else begin
            r.hit   = 1'b0;
            r.value = v[DIM_W-1:0];
        end
        return r;
    endfunction

endpackage

FILE: rtl/tisp_if.sv
// ---------------------------------------------------------------------------
// tisp_if: stream channels
// Valid/ready channels for input characters and parser results.
// ---------------------------------------------------------------------------
interface tisp_char_if;
    import tisp_pkg::*;

    logic       valid;
    logic       ready;
    char_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface tisp_result_if;
    import tisp_pkg::*;

    logic         valid;
    logic         ready;
    result_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/text_image_stream_parser_unit.sv
// ---------------------------------------------------------------------------
// text_image_stream_parser_unit: text image stream parser
// Parses a character stream into one header result and per-pixel results.
// ---------------------------------------------------------------------------
//  channel   dir  payload                              transfer
//  char_ch   in   char_code, start_req                 valid & ready
//  res_ch    out  kind, width, height, dims_clamped,   valid & ready
//                 row, col, red, green, blue, last_pixel
//
//  One character per cycle while the queue has room; the accumulator
//  update is times ten plus digit. A result passes through the queue and
//  the result register. Reset clears the parser phase and counters at once;
//  no clearing pass. A two-entry queue and the result register absorb
//  output stalls; input stalls only when the queue is full.
// ---------------------------------------------------------------------------
module text_image_stream_parser_unit (
    input  logic          clk,
    input  logic          rst_n,
    tisp_char_if.sink     char_ch,
    tisp_result_if.source res_ch
);
    import tisp_pkg::*;

    logic       push_valid;
    logic       push_ready;
    event_rec_t push_data;
    logic       pop_valid;
    logic       pop_ready;
    event_rec_t pop_data;

    tisp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_ch    (char_ch),
        .push_ready (push_ready),
        .push_valid (push_valid),
        .push_data  (push_data)
    );

    tisp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_data  (push_data),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_data   (pop_data),
        .pop_ready  (pop_ready)
    );

    tisp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_data  (pop_data),
        .pop_ready (pop_ready),
        .res_ch    (res_ch)
    );

endmodule

FILE: rtl/tisp_front.sv
// ---------------------------------------------------------------------------
// tisp_front: character parser
// Accepts characters, runs the decimal accumulator and phase sequence, and
// emits header and pixel events toward the queue.
// ---------------------------------------------------------------------------
module tisp_front (
    input  logic                 clk,
    input  logic                 rst_n,
    tisp_char_if.sink            char_ch,
    input  logic                 push_ready,
    output logic                 push_valid,
    output tisp_pkg::event_rec_t push_data
);
    import tisp_pkg::*;

    localparam logic [ACC_W-1:0] MIN_W_V = ACC_W'(MIN_W);
    localparam logic [ACC_W-1:0] MAX_W_V = ACC_W'(MAX_W);
    localparam logic [ACC_W-1:0] MIN_H_V = ACC_W'(MIN_H);
    localparam logic [ACC_W-1:0] MAX_H_V = ACC_W'(MAX_H);

    phase_t             phase_reg, phase_next, phase_cur;
    logic [ACC_W-1:0]   acc_reg, acc_next, acc_cur;
    logic [DIM_W-1:0]   width_reg, width_next, width_cur;
    logic [DIM_W-1:0]   height_reg, height_next, height_cur;
    logic               clamp_reg, clamp_next, clamp_cur;
    logic [COMP_W-1:0]  red_reg, red_next, red_cur;
    logic [COMP_W-1:0]  green_reg, green_next, green_cur;
    logic [DIM_W-1:0]   row_reg, row_next, row_cur;
    logic [DIM_W-1:0]   col_reg, col_next, col_cur;

    logic               accept;
    logic               start;
    logic               nl;
    logic [7:0]         c;
    logic [ACC_W-1:0]   digit_acc;
    logic [ACC_W-1:0]   dash_acc;
    logic [DIM_W-1:0]   col_inc;
    logic [DIM_W-1:0]   row_inc;
    dim_clamp_t         cl_w;
    dim_clamp_t         cl_h;
    dim_clamp_t         cl_dash;
    dim_clamp_t         cl_zero;

    assign char_ch.ready = push_ready;
    assign accept        = char_ch.valid && push_ready;
    assign c             = char_ch.data.char_code;
    assign start         = char_ch.data.start_req;
    assign nl            = (c == CHAR_NL);

    always_comb
    begin
        if (start)
        begin
            phase_cur  = PH_WIDTH;
            acc_cur    = '0;
            width_cur  = DIM_W'(MIN_W);
            height_cur = DIM_W'(MIN_H);
            clamp_cur  = 1'b0;
            red_cur    = '0;
            green_cur  = '0;
            row_cur    = '0;
            col_cur    = '0;
        end
        else
        begin
            phase_cur  = phase_reg;
            acc_cur    = acc_reg;
            width_cur  = width_reg;
            height_cur = height_reg;
            clamp_cur  = clamp_reg;
            red_cur    = red_reg;
            green_cur  = green_reg;
            row_cur    = row_reg;
            col_cur    = col_reg;
        end
    end

    assign digit_acc = (acc_cur << 3) + (acc_cur << 1) + {24'b0, c} - {24'b0, CHAR_ZERO};
    assign dash_acc  = {24'b0, c} - {24'b0, CHAR_ZERO};
    assign cl_w      = clamp_dim(acc_cur, MIN_W_V, MAX_W_V);
    assign cl_h      = clamp_dim(acc_cur, MIN_H_V, MAX_H_V);
    assign cl_dash   = clamp_dim({{(ACC_W-DIM_W){1'b0}}, width_cur}, MIN_H_V, MAX_H_V);
    assign cl_zero   = clamp_dim('0, MIN_H_V, MAX_H_V);
    assign col_inc   = col_cur + 1'b1;
    assign row_inc   = row_cur + 1'b1;

    always_comb
    begin
        phase_next  = phase_reg;
        acc_next    = acc_reg;
        width_next  = width_reg;
        height_next = height_reg;
        clamp_next  = clamp_reg;
        red_next    = red_reg;
        green_next  = green_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        push_valid  = 1'b0;
        push_data   = '0;

        if (accept)
        begin
            phase_next  = phase_cur;
            acc_next    = acc_cur;
            width_next  = width_cur;
            height_next = height_cur;
            clamp_next  = clamp_cur;
            red_next    = red_cur;
            green_next  = green_cur;
            row_next    = row_cur;
            col_next    = col_cur;

            case (phase_cur)
                PH_WIDTH:
                begin
                    if (nl)
                    begin
                        width_next = cl_w.value;
                        clamp_next = clamp_cur | cl_w.hit;
                        acc_next   = '0;
                        phase_next = PH_DASH_OR_H;
                    end
                    else
                    begin
                        acc_next = digit_acc;
                    end
                end
                PH_DASH_OR_H:
                begin
                    if (c == CHAR_DASH)
                    begin
                        height_next = cl_dash.value;
                        clamp_next  = clamp_cur | cl_dash.hit;
                        phase_next  = PH_SKIP1;
                        push_valid  = 1'b1;
                    end
                    else if (nl)
                    begin
                        height_next = cl_zero.value;
                        clamp_next  = clamp_cur | cl_zero.hit;
                        phase_next  = PH_SKIP2;
                        push_valid  = 1'b1;
                    end
                    else
                    begin
                        acc_next   = dash_acc;
                        phase_next = PH_HEIGHT;
                    end
                end
                PH_HEIGHT:
                begin
                    if (nl)
                    begin
                        height_next = cl_h.value;
                        clamp_next  = clamp_cur | cl_h.hit;
                        acc_next    = '0;
                        phase_next  = PH_SKIP2;
                        push_valid  = 1'b1;
                    end
                    else
                    begin
                        acc_next = digit_acc;
                    end
                end
                PH_SKIP2:
                begin
                    phase_next = PH_SKIP1;
                end
                PH_SKIP1:
                begin
                    acc_next   = '0;
                    phase_next = PH_RED;
                end
                PH_RED:
                begin
                    if (nl)
                    begin
                        red_next   = acc_cur[COMP_W-1:0];
                        acc_next   = '0;
                        phase_next = PH_GREEN;
                    end
                    else
                    begin
                        acc_next = digit_acc;
                    end
                end
                PH_GREEN:
                begin
                    if (nl)
                    begin
                        green_next = acc_cur[COMP_W-1:0];
                        acc_next   = '0;
                        phase_next = PH_BLUE;
                    end
                    else
                    begin
                        acc_next = digit_acc;
                    end
                end
                PH_BLUE:
                begin
                    if (nl)
                    begin
                        push_valid     = 1'b1;
                        push_data.kind = KIND_PIXEL;
                        push_data.row  = row_cur[POS_W-1:0];
                        push_data.col  = col_cur[POS_W-1:0];
                        push_data.red  = red_cur;
                        push_data.green = green_cur;
                        push_data.blue = acc_cur[COMP_W-1:0];
                        acc_next       = '0;
                        if (col_inc >= width_cur)
                        begin
                            col_next = '0;
                            row_next = row_inc;
                            phase_next = (row_inc >= height_cur) ? PH_DONE : PH_RED;
                        end
                        else
                        begin
                            col_next   = col_inc;
                            phase_next = PH_RED;
                        end
                    end
                    else
                    begin
                        acc_next = digit_acc;
                    end
                end
                PH_DONE:
                begin
                    phase_next = PH_DONE;
                end
                default:
                begin
                    phase_next = PH_DONE;
                end
            endcase

            push_data.width        = width_next;
            push_data.height       = height_next;
            push_data.dims_clamped = clamp_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_WIDTH;
            acc_reg    <= '0;
            width_reg  <= DIM_W'(MIN_W);
            height_reg <= DIM_W'(MIN_H);
            clamp_reg  <= 1'b0;
            red_reg    <= '0;
            green_reg  <= '0;
            row_reg    <= '0;
            col_reg    <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            acc_reg    <= acc_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            clamp_reg  <= clamp_next;
            red_reg    <= red_next;
            green_reg  <= green_next;
            row_reg    <= row_next;
            col_reg    <= col_next;
        end
    end

endmodule

FILE: rtl/tisp_queue.sv
// ---------------------------------------------------------------------------
// tisp_queue: event queue
// Two-entry queue between the parser and the output stage.
// ---------------------------------------------------------------------------
module tisp_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push_valid,
    input  tisp_pkg::event_rec_t push_data,
    output logic                 push_ready,
    output logic                 pop_valid,
    output tisp_pkg::event_rec_t pop_data,
    input  logic                 pop_ready
);
    import tisp_pkg::*;

    event_rec_t  mem_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        do_push;
    logic        do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: rtl/tisp_back.sv
// ---------------------------------------------------------------------------
// tisp_back: result stage
// Takes queued events, marks the final pixel and holds the result register.
// ---------------------------------------------------------------------------
module tisp_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pop_valid,
    input  tisp_pkg::event_rec_t pop_data,
    output logic                 pop_ready,
    tisp_result_if.source        res_ch
);
    import tisp_pkg::*;

    logic         out_valid_reg, out_valid_next;
    result_item_t out_data_reg;
    result_item_t out_data_next;
    logic         load;
    logic [DIM_W-1:0] row_inc;
    logic [DIM_W-1:0] col_inc;

    assign pop_ready    = !out_valid_reg || res_ch.ready;
    assign load         = pop_valid && pop_ready;
    assign res_ch.valid = out_valid_reg;
    assign res_ch.data  = out_data_reg;
    assign row_inc      = {1'b0, pop_data.row} + 1'b1;
    assign col_inc      = {1'b0, pop_data.col} + 1'b1;

    always_comb
    begin
        out_data_next.kind         = pop_data.kind;
        out_data_next.width        = pop_data.width;
        out_data_next.height       = pop_data.height;
        out_data_next.dims_clamped = pop_data.dims_clamped;
        out_data_next.row          = pop_data.row;
        out_data_next.col          = pop_data.col;
        out_data_next.red          = pop_data.red;
        out_data_next.green        = pop_data.green;
        out_data_next.blue         = pop_data.blue;
        out_data_next.last_pixel   = (pop_data.kind == KIND_PIXEL)
                                     && (row_inc == pop_data.height)
                                     && (col_inc == pop_data.width);
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (res_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_data_reg <= out_data_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
